/* hdl/drift_time_interpolator_macros.svh */
// Assertion macros for the drift time interpolator.
`ifndef DRIFT_TIME_INTERPOLATOR_MACROS_SVH
`define DRIFT_TIME_INTERPOLATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high
`define DTI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drift time interpolator: same-cycle check failed");
// Next-cycle implication, disabled while reset is high
`define DTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drift time interpolator: next-cycle check failed");
`else
`define DTI_ASSERT_NOW(label, clk, rst, ante, cons)
`define DTI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/dti_pkg.sv */
// Shared constants and types for the drift time interpolator.
package dti_pkg;

   localparam int SEGMENTS    = 15;
   localparam int TABLE_DEPTH = SEGMENTS + 1;

   localparam int INDEX_WIDTH = 4;
   localparam int DIST_WIDTH  = 16;
   localparam int TIME_WIDTH  = 14;
   localparam int NUM_WIDTH   = DIST_WIDTH + TIME_WIDTH;
   localparam int QUO_WIDTH   = TIME_WIDTH;
   localparam int DIV_STAGES  = QUO_WIDTH;

   // Operation codes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   // One divider stage: partial remainder, quotient so far and what rides along
   typedef struct packed {
      logic                  found;
      logic                  neg;
      logic [TIME_WIDTH-1:0] t0;
      logic [DIST_WIDTH-1:0] span;
      logic [NUM_WIDTH-1:0]  rem;
      logic [QUO_WIDTH-1:0]  quo;
   } div_stage_type;

endpackage

/* hdl/drift_time_interpolator.sv */
// A beat passes stages 1-3, the restoring divider (one quotient bit per stage) and the
// output register on its way to rsp_; one beat per cycle while rsp_ is not stalled.
// A stalled result holds the whole pipeline and stalls the request side.
// Reset (synchronous, active high) clears all valid bits; the breakpoint table
// is not cleared and holds undefined values until loaded.
module drift_time_interpolator import dti_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [INDEX_WIDTH-1:0] req_point_index,
   input  logic [DIST_WIDTH-1:0]  req_distance,
   input  logic [TIME_WIDTH-1:0]  req_breakpoint_time,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [TIME_WIDTH-1:0]  rsp_drift_time,
   output logic                   rsp_found
);

`include "drift_time_interpolator_macros.svh"

   // Breakpoint table
   logic [DIST_WIDTH-1:0] dist_table_ff [TABLE_DEPTH];
   logic [TIME_WIDTH-1:0] time_table_ff [TABLE_DEPTH];

   // Stage 1: selected segment
   logic                  s1_valid_ff;
   logic                  s1_found_ff, s1_found_in;
   logic [DIST_WIDTH-1:0] s1_dist_ff;
   logic [DIST_WIDTH-1:0] s1_d0_ff, s1_d0_in, s1_d1_ff, s1_d1_in;
   logic [TIME_WIDTH-1:0] s1_t0_ff, s1_t0_in, s1_t1_ff, s1_t1_in;

   // Stage 2: differences
   logic                  s2_valid_ff;
   logic                  s2_found_ff;
   logic                  s2_neg_ff, s2_neg_in;
   logic [DIST_WIDTH-1:0] s2_dx_ff, s2_span_ff;
   logic [TIME_WIDTH-1:0] s2_dt_ff, s2_dt_in;
   logic [TIME_WIDTH-1:0] s2_t0_ff;

   // Stage 3: product magnitude
   logic          s3_valid_ff;
   div_stage_type s3_ff, s3_in;

   // Divider stages
   logic          div_valid_ff [DIV_STAGES];
   div_stage_type div_ff       [DIV_STAGES];
   div_stage_type div_src      [DIV_STAGES];
   div_stage_type div_in       [DIV_STAGES];

   // Output register
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [TIME_WIDTH-1:0] rsp_time_ff, rsp_time_in;
   logic [TIME_WIDTH-1:0] fin_quo;

   logic advance;
   logic req_accept;

   // Hold every stage while the result beat is stalled
   assign advance    = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;

   // Write one breakpoint pair on a load beat
   always_ff @(posedge clock) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         if (req_accept && req_operation == OP_LOAD && int'(req_point_index) == j) begin
            dist_table_ff[j] <= req_distance;
            time_table_ff[j] <= req_breakpoint_time;
         end
      end
   end

   // Compare against every segment; the highest matching index wins
   always_comb begin
      s1_found_in = 1'b0;
      s1_d0_in    = dist_table_ff[0];
      s1_d1_in    = dist_table_ff[1];
      s1_t0_in    = time_table_ff[0];
      s1_t1_in    = time_table_ff[1];
      for (int i = 0; i < SEGMENTS; i++) begin
         if (req_distance > dist_table_ff[i] && req_distance < dist_table_ff[i+1]) begin
            s1_found_in = 1'b1;
            s1_d0_in    = dist_table_ff[i];
            s1_d1_in    = dist_table_ff[i+1];
            s1_t0_in    = time_table_ff[i];
            s1_t1_in    = time_table_ff[i+1];
         end
      end
      if (req_operation == OP_LOAD) begin
         s1_found_in = 1'b0;
      end
   end

   // Take the time step apart into magnitude and sign
   always_comb begin
      s2_neg_in = s1_t1_ff < s1_t0_ff;
      s2_dt_in  = s2_neg_in ? (s1_t0_ff - s1_t1_ff) : (s1_t1_ff - s1_t0_ff);
   end

   // Form the numerator magnitude and seed the divider
   always_comb begin
      s3_in.found = s2_found_ff;
      s3_in.neg   = s2_neg_ff;
      s3_in.t0    = s2_t0_ff;
      s3_in.span  = s2_span_ff;
      s3_in.rem   = NUM_WIDTH'(s2_dx_ff) * NUM_WIDTH'(s2_dt_ff);
      s3_in.quo   = '0;
   end

   // Restoring division: one quotient bit per stage, most significant first
   always_comb begin
      div_src[0] = s3_ff;
      for (int s = 1; s < DIV_STAGES; s++) begin
         div_src[s] = div_ff[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         div_in[s] = div_src[s];
         if (div_src[s].rem >= (NUM_WIDTH'(div_src[s].span) << (QUO_WIDTH - 1 - s))) begin
            div_in[s].rem = div_src[s].rem - (NUM_WIDTH'(div_src[s].span) << (QUO_WIDTH - 1 - s));
            div_in[s].quo[QUO_WIDTH-1-s] = 1'b1;
         end
      end
   end

   // Apply the sign to the quotient and add the segment start time, or give zero if not found
   assign fin_quo = div_ff[DIV_STAGES-1].quo;
   always_comb begin
      if (!div_ff[DIV_STAGES-1].found) begin
         rsp_time_in = '0;
      end else if (div_ff[DIV_STAGES-1].neg) begin
         rsp_time_in = div_ff[DIV_STAGES-1].t0 - fin_quo;
      end else begin
         rsp_time_in = div_ff[DIV_STAGES-1].t0 + fin_quo;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < DIV_STAGES; s++) begin
            div_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff     <= req_valid;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         div_valid_ff[0] <= s3_valid_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            div_valid_ff[s] <= div_valid_ff[s-1];
         end
         rsp_valid_ff <= div_valid_ff[DIV_STAGES-1];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_found_ff <= s1_found_in;
         s1_dist_ff  <= req_distance;
         s1_d0_ff    <= s1_d0_in;
         s1_d1_ff    <= s1_d1_in;
         s1_t0_ff    <= s1_t0_in;
         s1_t1_ff    <= s1_t1_in;

         s2_found_ff <= s1_found_ff;
         s2_neg_ff   <= s2_neg_in;
         s2_dt_ff    <= s2_dt_in;
         s2_dx_ff    <= s1_dist_ff - s1_d0_ff;
         s2_span_ff  <= s1_d1_ff - s1_d0_ff;
         s2_t0_ff    <= s1_t0_ff;

         s3_ff <= s3_in;
         for (int s = 0; s < DIV_STAGES; s++) begin
            div_ff[s] <= div_in[s];
         end

         rsp_found_ff <= div_ff[DIV_STAGES-1].found;
         rsp_time_ff  <= rsp_time_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_drift_time = rsp_time_ff;

   // Checks
   `DTI_ASSERT_NOW(a_not_found_zero, clock, reset, rsp_valid && !rsp_found, rsp_drift_time == '0)
   `DTI_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, s1_valid_ff)
   `DTI_ASSERT_NOW(a_div_rem_bound, clock, reset,
                   div_valid_ff[DIV_STAGES-1] && div_ff[DIV_STAGES-1].found,
                   div_ff[DIV_STAGES-1].rem < NUM_WIDTH'(div_ff[DIV_STAGES-1].span))

endmodule

/* sim/drift_time_interpolator_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the drift time interpolator: breakpoint loads, conversions, stalls.
module drift_time_interpolator_tb;
   import dti_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int DIST_MAX     = (1 << DIST_WIDTH) - 1;
   localparam int TIME_MAX     = (1 << TIME_WIDTH) - 1;

   // Shadow breakpoint table and queue of expected conversion results
   class drift_time_scoreboard;
      typedef struct {
         logic [TIME_WIDTH-1:0] drift_time;
         logic                  found;
      } drift_result_type;

      logic [DIST_WIDTH-1:0] brk_dist [TABLE_DEPTH];
      logic [TIME_WIDTH-1:0] brk_time [TABLE_DEPTH];
      drift_result_type      expected_results [$];
      int                    error_count;

      // Apply a load or predict a conversion for one accepted request beat
      function void note_request(logic op, logic [INDEX_WIDTH-1:0] idx,
                                 logic [DIST_WIDTH-1:0] dist_val,
                                 logic [TIME_WIDTH-1:0] btime);
         drift_result_type res;
         longint           d0, d1, t0, t1, quo;
         res.drift_time = '0;
         res.found      = 1'b0;
         if (op == OP_LOAD) begin
            if (idx < TABLE_DEPTH) begin
               brk_dist[idx] = dist_val;
               brk_time[idx] = btime;
            end
         end else begin
            // later segments overwrite earlier ones, so the highest match wins
            for (int seg = 0; seg < SEGMENTS; seg++) begin
               if (dist_val > brk_dist[seg] && dist_val < brk_dist[seg+1]) begin
                  d0 = longint'(brk_dist[seg]);
                  d1 = longint'(brk_dist[seg+1]);
                  t0 = longint'(brk_time[seg]);
                  t1 = longint'(brk_time[seg+1]);
                  // signed product, quotient truncated toward zero
                  quo = ((longint'(dist_val) - d0) * (t1 - t0)) / (d1 - d0);
                  res.drift_time = TIME_WIDTH'(t0 + quo);
                  res.found      = 1'b1;
               end
            end
         end
         expected_results = {expected_results, res};
      endfunction

      // Compare one accepted response beat with the oldest expectation
      function void check_response(logic [TIME_WIDTH-1:0] drift_time, logic found);
         drift_result_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected response beat: drift_time=%0d found=%0d", drift_time, found);
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         if (drift_time !== want.drift_time) begin
            $error("drift_time: expected %0d, actual %0d", want.drift_time, drift_time);
            error_count++;
         end
         if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                   clock               = 1'b0;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_stall;
   logic                   req_operation       = OP_LOAD;
   logic [INDEX_WIDTH-1:0] req_point_index     = '0;
   logic [DIST_WIDTH-1:0]  req_distance        = '0;
   logic [TIME_WIDTH-1:0]  req_breakpoint_time = '0;
   logic                   rsp_valid;
   logic                   rsp_stall           = 1'b0;
   logic [TIME_WIDTH-1:0]  rsp_drift_time;
   logic                   rsp_found;

   drift_time_scoreboard sb = new;

   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int beats_sent    = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit hold_request  = 1'b0;
   logic [DIST_WIDTH-1:0] sent_dist [TABLE_DEPTH];

   drift_time_interpolator u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_point_index     (req_point_index),
      .req_distance        (req_distance),
      .req_breakpoint_time (req_breakpoint_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drift_time      (rsp_drift_time),
      .rsp_found           (rsp_found)
   );

   always #5 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("drift_time_interpolator test failed");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      rsp_stall <= (hold_left > 0) || ($urandom_range(0, 99) < rx_idle_pct);
      if (hold_left > 0)
         hold_left--;
   end

   // Observe beats on both channels at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_operation, req_point_index, req_distance, req_breakpoint_time);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_drift_time, rsp_found);
      end
   end

   // Offer one request beat and hold it until accepted
   task automatic send_beat(input logic op, input logic [INDEX_WIDTH-1:0] idx,
                            input logic [DIST_WIDTH-1:0] dist_val,
                            input logic [TIME_WIDTH-1:0] btime);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_point_index     <= idx;
      req_distance        <= dist_val;
      req_breakpoint_time <= btime;
      if (op == OP_LOAD)
         sent_dist[idx] = dist_val;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
   endtask

   task automatic convert_distance(input logic [DIST_WIDTH-1:0] dist_val);
      send_beat(OP_CONVERT, INDEX_WIDTH'($urandom), dist_val, TIME_WIDTH'($urandom));
   endtask

   function automatic logic [TIME_WIDTH-1:0] pick_time();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return TIME_WIDTH'(TIME_MAX);
         default: return TIME_WIDTH'($urandom_range(0, TIME_MAX));
      endcase
   endfunction

   // One stretch of traffic: a fresh ascending table or a few stray loads, then conversions
   task automatic run_episode();
      int                    step_max, span_all, off, n_conv, seg, pick;
      int unsigned           acc, lo, hi;
      logic [DIST_WIDTH-1:0] new_dist [TABLE_DEPTH];
      if ($urandom_range(0, 99) < 70) begin
         case ($urandom_range(0, 3))
            0:       step_max = 3;
            1:       step_max = 200;
            2:       step_max = 4369;
            default: step_max = 9000;
         endcase
         span_all = SEGMENTS * step_max;
         acc = (span_all >= DIST_MAX) ? 0 : $urandom_range(0, DIST_MAX - span_all);
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            new_dist[k] = DIST_WIDTH'(acc);
            acc = acc + $urandom_range(0, step_max);
            if (acc > DIST_MAX)
               acc = DIST_MAX;
         end
         // load in a rotated order so the table is only coherent at the end
         off = $urandom_range(0, TABLE_DEPTH - 1);
         for (int k = 0; k < TABLE_DEPTH; k++)
            send_beat(OP_LOAD, INDEX_WIDTH'((k + off) % TABLE_DEPTH),
                      new_dist[(k + off) % TABLE_DEPTH], pick_time());
      end else begin
         // stray loads break the ordering and give overlapping segments
         repeat ($urandom_range(1, 4))
            send_beat(OP_LOAD, INDEX_WIDTH'($urandom), DIST_WIDTH'($urandom_range(0, DIST_MAX)),
                      pick_time());
      end
      n_conv = $urandom_range(4, 24);
      repeat (n_conv) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            seg = $urandom_range(0, SEGMENTS - 1);
            lo  = sent_dist[seg];
            hi  = sent_dist[seg+1];
            if (lo > hi) begin
               acc = lo;
               lo  = hi;
               hi  = acc;
            end
            convert_distance(DIST_WIDTH'($urandom_range(lo, hi)));
         end else if (pick < 75) begin
            convert_distance(sent_dist[$urandom_range(0, TABLE_DEPTH - 1)]);
         end else begin
            convert_distance(DIST_WIDTH'($urandom_range(0, DIST_MAX)));
         end
      end
   endtask

   task automatic run_phase(input int n_beats);
      int target;
      target = beats_sent + n_beats;
      while (beats_sent < target)
         run_episode();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: evenly spaced table with times swinging between the extremes
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_beat(OP_LOAD, INDEX_WIDTH'(i), DIST_WIDTH'(i * 4369),
                   (i % 2) ? TIME_WIDTH'(TIME_MAX) : TIME_WIDTH'(0));
      convert_distance('0);                      // equal to first breakpoint
      convert_distance(DIST_WIDTH'(DIST_MAX));   // equal to last breakpoint
      convert_distance(16'd4369);                // equal to an inner breakpoint
      convert_distance(16'd2184);                // rising segment
      convert_distance(16'd4370);                // falling segment, negative quotient truncated
      convert_distance(16'd65534);               // just below the top
      // move one breakpoint far out so two segments contain the same distance
      send_beat(OP_LOAD, INDEX_WIDTH'(5), 16'd60000, 14'd8000);
      convert_distance(16'd50000);

      // Random: slow receiver, then slow sender, then full rate with a long hold-off
      tx_idle_pct = 17;
      rx_idle_pct = 88;
      run_phase(470);
      tx_idle_pct = 88;
      rx_idle_pct = 17;
      run_phase(470);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_phase(230);
      hold_request = 1'b1;
      run_phase(230);
      req_valid <= 1'b0;

      // Drain outstanding results, then allow stray beats to show
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("drift_time_interpolator test passed");
      else
         $display("drift_time_interpolator test failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/dti_pkg.sv
hdl/drift_time_interpolator.sv
sim/drift_time_interpolator_tb.sv
